FILE: rtl/led_bar_pattern_sequencer_macros.svh
// Assertion macros shared by the sequencer modules.
`ifndef LED_BAR_PATTERN_SEQUENCER_MACROS_SVH
`define LED_BAR_PATTERN_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LBPS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lbps_pkg.sv
// Types and constants shared by the LED bar pattern sequencer modules.
package lbps_pkg;

    localparam int unsigned LAMPS = 6;
    localparam int unsigned LAMP_IDX_W = 3;
    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned LAMP_W = 7;
    localparam int unsigned PAT_W = 2;
    localparam int unsigned IN_W = 104;
    localparam int unsigned OUT_W = 104;
    localparam int unsigned BUSY_BIT = LAMPS * LEVEL_W;

    localparam logic [15:0] TICK_MS = 16'd20;

    localparam logic [PAT_W-1:0] PAT_IDLE = 2'd0;
    localparam logic [PAT_W-1:0] PAT_SCAN = 2'd1;
    localparam logic [PAT_W-1:0] PAT_SWEEP = 2'd2;
    localparam logic [PAT_W-1:0] PAT_WIGWAG = 2'd3;

    localparam logic [2:0] MODE_PASS = 3'd0;
    localparam logic [2:0] MODE_CLEAR = 3'd1;
    localparam logic [2:0] MODE_SCAN = 3'd2;
    localparam logic [2:0] MODE_SWEEP = 3'd3;
    localparam logic [2:0] MODE_WIGWAG = 3'd4;

    localparam logic [LAMP_W-1:0] LAMP_FULL = 7'd100;
    localparam logic [15:0] FADE_MUL = 16'd205;

    typedef struct packed {
        logic [2:0] mode;
        logic [LAMP_IDX_W-1:0] scan_lamp;
        logic [LAMP_IDX_W-1:0] sweep_hi;
        logic [LAMP_IDX_W-1:0] sweep_lo;
        logic sweep_lo_ok;
        logic [LAMP_W-1:0] sweep_f5;
        logic wig_left;
    } lbps_ctl_t;

endpackage

FILE: rtl/lbps_ctrl.sv
// Pattern and timer control shared by all lamp lanes.
`include "led_bar_pattern_sequencer_macros.svh"

module lbps_ctrl
    import lbps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  logic [PAT_W-1:0] pattern,
    input  logic [LEVEL_W-1:0] level0,
    input  logic [LEVEL_W-1:0] level1,
    output lbps_ctl_t ctl,
    output logic busy
);

    logic [15:0] elapsed_reg;
    logic [15:0] elapsed_next;
    logic [PAT_W-1:0] cur_reg;
    logic [15:0] e_eff;
    logic clr;
    logic [LEVEL_W-1:0] sweep_src;
    logic [LAMP_W-1:0] sweep_val;
    logic [LAMP_IDX_W-1:0] sweep_p;
    logic [4:0] sweep_f;

    always_comb
    begin
        e_eff = (pattern != cur_reg) ? 16'd0 : elapsed_reg;
        sweep_src = (level0 != '0) ? level0 : level1;
        sweep_val = (sweep_src > 16'd119) ? 7'd119 : sweep_src[LAMP_W-1:0];
        if (sweep_val < 7'd20)
        begin
            sweep_p = 3'd0;
            sweep_f = sweep_val[4:0];
        end
        else if (sweep_val < 7'd40)
        begin
            sweep_p = 3'd1;
            sweep_f = 5'(sweep_val - 7'd20);
        end
        else if (sweep_val < 7'd60)
        begin
            sweep_p = 3'd2;
            sweep_f = 5'(sweep_val - 7'd40);
        end
        else if (sweep_val < 7'd80)
        begin
            sweep_p = 3'd3;
            sweep_f = 5'(sweep_val - 7'd60);
        end
        else if (sweep_val < 7'd100)
        begin
            sweep_p = 3'd4;
            sweep_f = 5'(sweep_val - 7'd80);
        end
        else
        begin
            sweep_p = 3'd5;
            sweep_f = 5'(sweep_val - 7'd100);
        end

        ctl.mode = MODE_PASS;
        ctl.scan_lamp = 3'd0;
        ctl.sweep_hi = 3'd5 - sweep_p;
        ctl.sweep_lo = 3'd4 - sweep_p;
        ctl.sweep_lo_ok = (sweep_p != 3'd5);
        ctl.sweep_f5 = {sweep_f, 2'b00} + {2'b00, sweep_f};
        ctl.wig_left = 1'b0;
        clr = 1'b0;

        case (pattern)
            PAT_IDLE:
            begin
                if (cur_reg != PAT_IDLE)
                begin
                    ctl.mode = MODE_CLEAR;
                    clr = 1'b1;
                end
            end
            PAT_SCAN:
            begin
                ctl.mode = MODE_SCAN;
                clr = !((e_eff < 16'd1000) || ((e_eff >= 16'd1100) && (e_eff < 16'd1200)));
                if (e_eff < 16'd100)
                    ctl.scan_lamp = 3'd0;
                else if (e_eff < 16'd200)
                    ctl.scan_lamp = 3'd1;
                else if (e_eff < 16'd300)
                    ctl.scan_lamp = 3'd2;
                else if (e_eff < 16'd400)
                    ctl.scan_lamp = 3'd3;
                else if (e_eff < 16'd500)
                    ctl.scan_lamp = 3'd4;
                else if (e_eff < 16'd600)
                    ctl.scan_lamp = 3'd5;
                else if (e_eff < 16'd700)
                    ctl.scan_lamp = 3'd4;
                else if (e_eff < 16'd800)
                    ctl.scan_lamp = 3'd3;
                else if (e_eff < 16'd900)
                    ctl.scan_lamp = 3'd2;
                else if (e_eff < 16'd1000)
                    ctl.scan_lamp = 3'd1;
                else
                    ctl.scan_lamp = 3'd0;
            end
            PAT_SWEEP:
            begin
                ctl.mode = MODE_SWEEP;
            end
            PAT_WIGWAG:
            begin
                ctl.mode = MODE_WIGWAG;
                clr = (e_eff >= 16'd400);
                ctl.wig_left = clr || (e_eff < 16'd200);
            end
            default:
            begin
                ctl.mode = MODE_PASS;
            end
        endcase

        elapsed_next = (clr ? 16'd0 : e_eff) + TICK_MS;
        busy = (pattern != PAT_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            cur_reg <= PAT_IDLE;
        end
        else if (step)
        begin
            elapsed_reg <= elapsed_next;
            cur_reg <= pattern;
        end
    end

    `LBPS_ASSERT_IMPL(a_scan_timer_bound, cur_reg == PAT_SCAN,
        elapsed_reg < 16'd1200 + TICK_MS, "scanner timer out of range")
    `LBPS_ASSERT_IMPL(a_wigwag_timer_bound, cur_reg == PAT_WIGWAG,
        elapsed_reg < 16'd400 + TICK_MS, "wig-wag timer out of range")
    `LBPS_ASSERT_NEXT(a_change_restarts_timer, step && (pattern != cur_reg),
        elapsed_reg == TICK_MS, "pattern change did not restart the timer")

endmodule

FILE: rtl/lbps_lane.sv
// One lamp lane: stored level and its next value for the current tick.
module lbps_lane
    import lbps_pkg::*;
#(
    parameter int unsigned IDX = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  lbps_ctl_t ctl,
    input  logic [LEVEL_W-1:0] in_level,
    output logic [LEVEL_W-1:0] out_level
);

    localparam logic [LAMP_IDX_W-1:0] MY_IDX = LAMP_IDX_W'(IDX);
    localparam logic [LAMP_IDX_W-1:0] LAST_IDX = LAMP_IDX_W'(LAMPS - 1);

    logic [LAMP_W-1:0] lamp_reg;
    logic [LAMP_W-1:0] lamp_next;
    logic [15:0] fade_prod;

    always_comb
    begin
        fade_prod = {8'b0, lamp_reg, 1'b0} * FADE_MUL;
        case (ctl.mode)
            MODE_PASS:
                lamp_next = lamp_reg;
            MODE_CLEAR:
                lamp_next = '0;
            MODE_SCAN:
                lamp_next = (ctl.scan_lamp == MY_IDX) ? LAMP_FULL : {1'b0, fade_prod[15:10]};
            MODE_SWEEP:
            begin
                if (ctl.sweep_hi == MY_IDX)
                    lamp_next = LAMP_FULL - ctl.sweep_f5;
                else if (ctl.sweep_lo_ok && (ctl.sweep_lo == MY_IDX))
                    lamp_next = ctl.sweep_f5;
                else
                    lamp_next = '0;
            end
            MODE_WIGWAG:
            begin
                if ((MY_IDX == '0) && ctl.wig_left)
                    lamp_next = LAMP_FULL;
                else if ((MY_IDX == LAST_IDX) && !ctl.wig_left)
                    lamp_next = LAMP_FULL;
                else
                    lamp_next = '0;
            end
            default:
                lamp_next = lamp_reg;
        endcase
        out_level = (ctl.mode == MODE_PASS) ? in_level : {{(LEVEL_W - LAMP_W){1'b0}}, lamp_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lamp_reg <= '0;
        else if (step)
            lamp_reg <= lamp_next;
    end

endmodule

FILE: rtl/lbps_outbuf.sv
// Merging stage: packs the lane levels and busy flag into a registered, skid-buffered item.
`include "led_bar_pattern_sequencer_macros.svh"

module lbps_outbuf
    import lbps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_fire,
    input  logic [LEVEL_W-1:0] lane_level [LAMPS],
    input  logic busy,
    output logic in_ready,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata
);

    logic [OUT_W-1:0] word;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] skid_data_reg;
    logic out_valid_reg;
    logic skid_valid_reg;
    logic out_fire;

    always_comb
    begin
        word = '0;
        for (int i = 0; i < LAMPS; i++)
            word[i*LEVEL_W +: LEVEL_W] = lane_level[i];
        word[BUSY_BIT] = busy;
    end

    assign out_fire = out_valid_reg && m_axis_tready;
    assign in_ready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
                out_data_reg <= word;
            else
                skid_data_reg <= word;
        end
        else if (out_fire && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

    `LBPS_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid stage holds an item while the output register is empty")
    `LBPS_ASSERT_NEXT(a_stall_fills_skid, in_fire && out_valid_reg && !m_axis_tready,
        skid_valid_reg, "item taken during a stall was not kept in the skid stage")
    `LBPS_ASSERT_NEXT(a_skid_drains, out_fire && skid_valid_reg,
        out_valid_reg && !skid_valid_reg, "skid item was not moved to the output")

endmodule

FILE: rtl/led_bar_pattern_sequencer.sv
// Top level of the six-lamp LED bar pattern sequencer.
// Each input item is one timer tick; it produces exactly one result item. The block takes one
// item per clock cycle while s_axis_tready is high; the pattern logic and all six lamp lanes are
// combinational, and the result is written to the output register, or to the one-item skid stage
// behind it when a result still waits there. The skid stage keeps input accepted for one more item
// while a result waits, so input stalls only when the output register and the skid stage are full.
module led_bar_pattern_sequencer
    import lbps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // Fields from bit 0: pattern, in_level0, in_level1, in_level2, in_level3, in_level4, in_level5.
    input  logic [IN_W-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // Fields from bit 0: out_level0 .. out_level5, busy_res.
    output logic [OUT_W-1:0] m_axis_tdata
);

    logic step;
    logic busy;
    lbps_ctl_t ctl;
    logic [LEVEL_W-1:0] in_level [LAMPS];
    logic [LEVEL_W-1:0] lane_level [LAMPS];

    assign step = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        for (int i = 0; i < LAMPS; i++)
            in_level[i] = s_axis_tdata[PAT_W + i*LEVEL_W +: LEVEL_W];
    end

    lbps_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .pattern (s_axis_tdata[PAT_W-1:0]),
        .level0  (in_level[0]),
        .level1  (in_level[1]),
        .ctl     (ctl),
        .busy    (busy)
    );

    for (genvar g = 0; g < LAMPS; g++)
    begin : g_lane
        lbps_lane #(
            .IDX (g)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (step),
            .ctl       (ctl),
            .in_level  (in_level[g]),
            .out_level (lane_level[g])
        );
    end

    lbps_outbuf u_outbuf (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (step),
        .lane_level    (lane_level),
        .busy          (busy),
        .in_ready      (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
